>>> rtl/core/pats_pkg.sv
// ----------------------------------------------------------------------------
// pats_pkg
// Shared sizes, operation codes and types of the task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pats_pkg;

   localparam int NUM_TASKS      = 1024;
   localparam int NUM_WORKERS    = 8;
   localparam int NUM_PRIORITIES = 3;
   localparam int QUEUE_DEPTH    = 1024;

   localparam int TASK_W  = $clog2(NUM_TASKS);
   localparam int JC_W    = 11;
   localparam int OP_W    = 3;
   localparam int PRIO_W  = 2;
   localparam int AFF_W   = 4;
   localparam int WID_W   = 3;

   localparam int NUM_QUEUES  = (NUM_WORKERS + 1) * NUM_PRIORITIES;
   localparam int QIDX_W      = $clog2(NUM_QUEUES);
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = PTR_W + 1;
   localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
   localparam logic [OP_W-1:0] OP_SUBMIT   = 3'd1;
   localparam logic [OP_W-1:0] OP_POP      = 3'd2;
   localparam logic [OP_W-1:0] OP_COMPLETE = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [TASK_W-1:0] task_id;
      logic [TASK_W-1:0] parent_id;
      logic [PRIO_W-1:0] priority_req;
      logic [AFF_W-1:0]  affinity;
      logic [WID_W-1:0]  worker_id;
      logic              batch_last;
   } req_type;

   typedef struct packed {
      logic [TASK_W-1:0] result_task;
      logic              found;
      logic              is_done;
      logic              status;
      logic              batch_end;
   } rsp_type;

   typedef struct packed {
      logic [TASK_W-1:0] parent;
      logic [PRIO_W-1:0] prio;
      logic [AFF_W-1:0]  aff;
   } info_type;

   typedef struct packed {
      logic load;
      logic start;
      logic rd_pid;
      logic inc_pid;
      logic sub_upd;
      logic rd_par;
      logic par_upd;
      logic enq;
      logic zero_tid;
      logic pop_fin;
      logic qry_fin;
      logic out_load;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            tid_zero;
      logic            par_zero;
      logic            old_two;
      logic            clr_last;
      logic            out_busy;
   } stat_type;

endpackage

`default_nettype wire

>>> rtl/core/pats_ifs.sv
// ----------------------------------------------------------------------------
// pats_ifs
// Request and response channel interfaces with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pats_req_if;
   logic              valid;
   logic              ready;
   pats_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface pats_rsp_if;
   logic              valid;
   logic              ready;
   pats_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pats_ctrl.sv
// ----------------------------------------------------------------------------
// pats_ctrl
// Sequencer that steps each operation through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pats_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire pats_pkg::stat_type stat,
   output pats_pkg::cmd_type       cmd
);

   typedef enum logic [13:0] {
      ST_CLEAR  = 14'b00000000000001,
      ST_IDLE   = 14'b00000000000010,
      ST_READ   = 14'b00000000000100,
      ST_CR2    = 14'b00000000001000,
      ST_CR3    = 14'b00000000010000,
      ST_SB2    = 14'b00000000100000,
      ST_CP2    = 14'b00000001000000,
      ST_CP3    = 14'b00000010000000,
      ST_ENQ    = 14'b00000100000000,
      ST_ZERO   = 14'b00001000000000,
      ST_POP2   = 14'b00010000000000,
      ST_QRY2   = 14'b00100000000000,
      ST_FINISH = 14'b01000000000000,
      ST_SPARE  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.start = 1'b1;
            case (stat.op)
               pats_pkg::OP_CREATE:   state_in = ST_CR2;
               pats_pkg::OP_SUBMIT:   state_in = stat.tid_zero ? ST_FINISH : ST_SB2;
               pats_pkg::OP_POP:      state_in = ST_POP2;
               pats_pkg::OP_COMPLETE: state_in = stat.tid_zero ? ST_FINISH : ST_CP2;
               pats_pkg::OP_QUERY:    state_in = ST_QRY2;
               default:               state_in = ST_FINISH;
            endcase
         end
         ST_CR2: begin
            cmd.rd_pid = 1'b1;
            state_in   = ST_CR3;
         end
         ST_CR3: begin
            cmd.inc_pid = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_SB2: begin
            cmd.sub_upd = 1'b1;
            state_in    = stat.old_two ? ST_ENQ : ST_FINISH;
         end
         ST_CP2: begin
            cmd.rd_par = 1'b1;
            state_in   = stat.par_zero ? ST_ZERO : ST_CP3;
         end
         ST_CP3: begin
            cmd.par_upd = 1'b1;
            state_in    = stat.old_two ? ST_ENQ : ST_ZERO;
         end
         ST_ENQ: begin
            cmd.enq  = 1'b1;
            state_in = (stat.op == pats_pkg::OP_COMPLETE) ? ST_ZERO : ST_FINISH;
         end
         ST_ZERO: begin
            cmd.zero_tid = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_POP2: begin
            cmd.pop_fin = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_QRY2: begin
            cmd.qry_fin = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/pats_dp.sv
// ----------------------------------------------------------------------------
// pats_dp
// Task tables, queue store, queue pointers and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module pats_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pats_pkg::cmd_type cmd,
   output pats_pkg::stat_type     stat,
   input  wire pats_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pats_pkg::rsp_type      rsp_data
);

   localparam int TW = pats_pkg::TASK_W;
   localparam int JW = pats_pkg::JC_W;
   localparam int QW = pats_pkg::QIDX_W;
   localparam int PW = pats_pkg::PTR_W;
   localparam int CW = pats_pkg::QCNT_W;
   localparam int AW = pats_pkg::STORE_AW;

   localparam logic [pats_pkg::PRIO_W-1:0] PRIO_SAT =
      pats_pkg::PRIO_W'(pats_pkg::NUM_PRIORITIES - 1);

   // Latched request.
   pats_pkg::req_type req_ff;
   logic [TW-1:0]     alloc_ff, alloc_in;
   logic [TW-1:0]     par_ff;

   // Memories and their registered read data.
   logic [JW-1:0]          jc_mem    [pats_pkg::NUM_TASKS];
   pats_pkg::info_type     info_mem  [pats_pkg::NUM_TASKS];
   logic                   open_mem  [pats_pkg::NUM_TASKS];
   logic [TW-1:0]          store_mem [pats_pkg::STORE_DEPTH];
   logic [JW-1:0]          jc_rd_ff;
   pats_pkg::info_type     info_rd_ff;
   logic                   open_rd_ff;
   logic [TW-1:0]          store_rd_ff;

   logic [PW-1:0] head_ff [pats_pkg::NUM_QUEUES];
   logic [PW-1:0] tail_ff [pats_pkg::NUM_QUEUES];
   logic [CW-1:0] cnt_ff  [pats_pkg::NUM_QUEUES];

   logic [TW-1:0] clr_ff;

   logic [TW-1:0] res_ff;
   logic          found_ff, done_ff, status_ff;

   logic is_create, is_submit, is_pop, is_complete, is_query, tid_zero;
   logic [TW-1:0] nid;

   assign is_create   = (req_ff.opcode == pats_pkg::OP_CREATE);
   assign is_submit   = (req_ff.opcode == pats_pkg::OP_SUBMIT);
   assign is_pop      = (req_ff.opcode == pats_pkg::OP_POP);
   assign is_complete = (req_ff.opcode == pats_pkg::OP_COMPLETE);
   assign is_query    = (req_ff.opcode == pats_pkg::OP_QUERY);
   assign tid_zero    = (req_ff.task_id == '0);

   // The id counter wraps and never hands out zero.
   always_comb begin
      nid = alloc_ff + TW'(1);
      if (nid == '0) nid = TW'(1);
      alloc_in = (cmd.start && is_create) ? nid : alloc_ff;
   end

   // Pop: own queue before global queue at each priority, 0 first.
   logic          pop_hit;
   logic [QW-1:0] pop_q;
   always_comb begin
      logic [QW-1:0] wq;
      pop_hit = 1'b0;
      pop_q   = '0;
      wq      = '0;
      for (int p = 0; p < pats_pkg::NUM_PRIORITIES; p++) begin
         wq = QW'((int'(req_ff.worker_id) + 1) * pats_pkg::NUM_PRIORITIES + p);
         if (!pop_hit && int'(req_ff.worker_id) < pats_pkg::NUM_WORKERS
             && cnt_ff[wq] != '0) begin
            pop_hit = 1'b1;
            pop_q   = wq;
         end
         if (!pop_hit && cnt_ff[QW'(p)] != '0) begin
            pop_hit = 1'b1;
            pop_q   = QW'(p);
         end
      end
   end

   // Enqueue target from the stored priority and affinity.
   logic [TW-1:0] enq_id;
   logic [QW-1:0] enq_q;
   logic          enq_full;
   always_comb begin
      int pr;
      pr = int'(info_rd_ff.prio);
      if (pr >= pats_pkg::NUM_PRIORITIES) pr = pats_pkg::NUM_PRIORITIES - 1;
      if (info_rd_ff.aff == '0 || int'(info_rd_ff.aff) > pats_pkg::NUM_WORKERS) begin
         enq_q = QW'(pr);
      end else begin
         enq_q = QW'(int'(info_rd_ff.aff) * pats_pkg::NUM_PRIORITIES + pr);
      end
      enq_id   = is_submit ? req_ff.task_id : par_ff;
      enq_full = (cnt_ff[enq_q] == CW'(pats_pkg::QUEUE_DEPTH));
   end

   // Job count port selection.
   logic          jc_we, jc_re;
   logic [TW-1:0] jc_wa, jc_ra;
   logic [JW-1:0] jc_wd;
   always_comb begin
      jc_we = 1'b0;
      jc_wa = req_ff.task_id;
      jc_wd = '0;
      jc_re = 1'b0;
      jc_ra = req_ff.task_id;
      if (cmd.start && is_create) begin
         jc_we = 1'b1;
         jc_wa = nid;
         jc_wd = JW'(2);
      end
      if (cmd.inc_pid) begin
         jc_we = (req_ff.parent_id != '0);
         jc_wa = req_ff.parent_id;
         jc_wd = jc_rd_ff + JW'(1);
      end
      if (cmd.sub_upd) begin
         jc_we = 1'b1;
         jc_wd = jc_rd_ff - JW'(1);
      end
      if (cmd.par_upd) begin
         jc_we = 1'b1;
         jc_wa = par_ff;
         jc_wd = jc_rd_ff - JW'(1);
      end
      if (cmd.zero_tid) begin
         jc_we = 1'b1;
      end
      if (cmd.start && is_submit) jc_re = 1'b1;
      if (cmd.rd_pid) begin
         jc_re = 1'b1;
         jc_ra = req_ff.parent_id;
      end
      if (cmd.rd_par) begin
         jc_re = 1'b1;
         jc_ra = info_rd_ff.parent;
      end
   end

   always_ff @(posedge clock) begin
      if (jc_we) jc_mem[jc_wa] <= jc_wd;
      if (jc_re) jc_rd_ff <= jc_mem[jc_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.start && is_create) begin
         info_mem[nid] <= '{parent: req_ff.parent_id, aff: req_ff.affinity,
                            prio: (int'(req_ff.priority_req) >= pats_pkg::NUM_PRIORITIES)
                                  ? PRIO_SAT : req_ff.priority_req};
      end
      if (cmd.start && (is_submit || is_complete)) begin
         info_rd_ff <= info_mem[req_ff.task_id];
      end else if (cmd.rd_par) begin
         info_rd_ff <= info_mem[info_rd_ff.parent];
      end
   end

   // Open flags are swept to zero after reset.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         open_mem[clr_ff] <= 1'b0;
      end else if (cmd.start && !tid_zero && (is_submit || is_complete)) begin
         open_mem[req_ff.task_id] <= is_submit;
      end
      if (cmd.start && is_query) open_rd_ff <= open_mem[req_ff.task_id];
   end

   always_ff @(posedge clock) begin
      if (cmd.enq && !enq_full) begin
         store_mem[AW'({enq_q, tail_ff[enq_q]})] <= enq_id;
      end
      if (cmd.start && is_pop) begin
         store_rd_ff <= store_mem[AW'({pop_q, head_ff[pop_q]})];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < pats_pkg::NUM_QUEUES; q++) begin
            head_ff[q] <= '0;
            tail_ff[q] <= '0;
            cnt_ff[q]  <= '0;
         end
      end else if (cmd.enq && !enq_full) begin
         tail_ff[enq_q] <= tail_ff[enq_q] + PW'(1);
         cnt_ff[enq_q]  <= cnt_ff[enq_q] + CW'(1);
      end else if (cmd.start && is_pop && pop_hit) begin
         head_ff[pop_q] <= head_ff[pop_q] + PW'(1);
         cnt_ff[pop_q]  <= cnt_ff[pop_q] - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff  <= '0;
         clr_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         alloc_ff <= alloc_in;
         if (cmd.clear) clr_ff <= clr_ff + TW'(1);
         if (cmd.out_load) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff    <= req_data;
         res_ff    <= '0;
         found_ff  <= 1'b0;
         done_ff   <= 1'b0;
         status_ff <= 1'b0;
      end
      if (cmd.start && is_create) begin
         res_ff   <= nid;
         found_ff <= 1'b1;
      end
      if (cmd.start && is_pop) found_ff <= pop_hit;
      if (cmd.pop_fin) res_ff <= found_ff ? store_rd_ff : '0;
      if (cmd.qry_fin) done_ff <= !open_rd_ff;
      if (cmd.enq) status_ff <= enq_full;
      if (cmd.rd_par) par_ff <= info_rd_ff.parent;
      if (cmd.out_load) begin
         rsp_data <= '{result_task: res_ff, found: found_ff, is_done: done_ff,
                       status: status_ff, batch_end: req_ff.batch_last};
      end
   end

   assign stat.op       = req_ff.opcode;
   assign stat.tid_zero = tid_zero;
   assign stat.par_zero = (info_rd_ff.parent == '0);
   assign stat.old_two  = (jc_rd_ff == JW'(2));
   assign stat.clr_last = (clr_ff == '1);
   assign stat.out_busy = rsp_valid && !rsp_ready;

endmodule

`default_nettype wire

>>> rtl/core/priority_affinity_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_affinity_task_scheduler_unit
// Task scheduler with priority queues and per-worker affinity.
// ----------------------------------------------------------------------------
// One item is taken at a time. The task tables are single-port, so each step of
// an operation reads or writes them in turn: create reads and then increments
// the parent's job count, submit decrements the task's count and may enqueue it,
// complete reads the parent and, if there is one, decrements its count and may
// enqueue it, then clears the task's count; pop and query finish their read. An
// unknown operation and a submit or complete of id zero go straight to the
// response. The next item is accepted in the cycle after the response is loaded.
// After reset the 1024 open flags are swept to zero, during which no item is
// accepted. The response register lets the next item be accepted while a response still waits to be taken.
`default_nettype none

module priority_affinity_task_scheduler_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   pats_req_if.sink   req_ch,
   pats_rsp_if.source rsp_ch
);

   pats_pkg::cmd_type  cmd;
   pats_pkg::stat_type stat;

   pats_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pats_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_ch.data),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (rsp_ch.data)
   );

   a_found_has_id: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.data.found |-> rsp_ch.data.result_task != '0)
      else $error("found response without a task id");

   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.data.status && (rsp_ch.data.found || rsp_ch.data.is_done)))
      else $error("overflow flagged on an operation that does not push");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("second item accepted while one is in progress");

endmodule

`default_nettype wire
